// ----- rtl/core/lru_pkg.sv -----
package lru_pkg;

    // Geometry
    localparam int MAX_FRAMES     = 16;
    localparam int WORDS_PER_PAGE = 10;
    localparam int NUM_PAGES      = 32;
    localparam int FRAME_W        = $clog2(MAX_FRAMES);
    localparam int PAGE_W         = $clog2(NUM_PAGES);
    localparam int ADDR_W         = 9;
    localparam int OFFSET_W       = 4;
    localparam int STAMP_W        = 16;
    localparam int COUNT_W        = 16;
    localparam int CFG_W          = 5;
    localparam int CFG_RESET      = 4;

    // Address / WORDS_PER_PAGE as (addr * DIV_MUL) >> DIV_SHIFT, exact for addr < 1029
    localparam int DIV_MUL        = 205;
    localparam int DIV_SHIFT      = 11;
    localparam int PROD_W         = ADDR_W + 8;
    localparam int QUOT_W         = PROD_W - DIV_SHIFT;

    typedef struct packed {
        logic [ADDR_W-1:0] word_address;
        logic              start_run;
    } t_in_item;

    typedef struct packed {
        logic                hit;
        logic [FRAME_W-1:0]  frame_slot;
        logic [PAGE_W-1:0]   page_number;
        logic [OFFSET_W-1:0] page_offset;
        logic                evicted_valid;
        logic [PAGE_W-1:0]   evicted_page;
        logic [COUNT_W-1:0]  fault_total;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

// ----- rtl/core/lru_page_replacement_unit.sv -----
// LRU page replacement unit.
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one word address
// per item plus a start flag that empties all frames and clears the reference
// and fault counters before the item is handled. Output channel (o_out_valid /
// i_out_stall / o_out_item) returns one result per item: hit, frame slot, page,
// offset, evicted page and the running fault total.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
// number of frames in use; 0 acts as 1 and values above 16 act as 16.
// Timing: after an item is accepted a sequencer walks the frames one per cycle
// with a single match / age comparator, stopping early on a hit, then updates the
// frame in an update step; it visits at most the frames in use.
// The result sits in an output register; the block stalls input while it works
// on an item and holds in its update step while a stalled result is still
// waiting to be taken.
// Reset: all frames empty, counters zero, frames in use = 4, no result pending.
module lru_page_replacement_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  lru_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lru_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lru_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int FW = lru_pkg::FRAME_W;
    localparam int PW = lru_pkg::PAGE_W;
    localparam int SW = lru_pkg::STAMP_W;
    localparam int CW = lru_pkg::COUNT_W;
    localparam int NF = lru_pkg::MAX_FRAMES;

    // Control state
    lru_pkg::t_state               r_state, n_state;
    logic [lru_pkg::CFG_W-1:0]     r_frames, n_frames;
    logic [NF-1:0]                 r_valid, n_valid;
    logic [SW-1:0]                 r_ref_idx, n_ref_idx;
    logic [CW-1:0]                 r_fault, n_fault;
    logic                          r_out_valid, n_out_valid;

    // Per-item working registers
    logic [PW-1:0]                 r_page, n_page;
    logic [lru_pkg::OFFSET_W-1:0]  r_offset, n_offset;
    logic [FW-1:0]                 r_idx, n_idx;
    logic [FW-1:0]                 r_limit_m1, n_limit_m1;
    logic                          r_hit, n_hit;
    logic [FW-1:0]                 r_slot, n_slot;
    logic                          r_empty_found, n_empty_found;
    logic [FW-1:0]                 r_empty_slot, n_empty_slot;
    logic [SW-1:0]                 r_best_age, n_best_age;
    logic [PW-1:0]                 r_best_page, n_best_page;
    lru_pkg::t_out_item            r_out, n_out;

    // Frame table
    logic [PW-1:0]                 r_frame_page [NF];
    logic [SW-1:0]                 r_last_use   [NF];
    logic                          w_en;
    logic [FW-1:0]                 w_slot;
    logic                          w_fill;

    // Address split and scan helpers
    logic [lru_pkg::PROD_W-1:0]    w_prod;
    logic [lru_pkg::QUOT_W-1:0]    w_quot;
    logic [lru_pkg::ADDR_W-1:0]    w_base;
    logic [SW-1:0]                 w_age;
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_evict;
    logic [FW-1:0]                 w_upd_slot;

    assign o_in_stall  = (r_state != lru_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Divide by the page size through a reciprocal multiply
    assign w_prod = lru_pkg::PROD_W'(i_in_item.word_address)
                  * lru_pkg::PROD_W'(lru_pkg::DIV_MUL);
    assign w_quot = w_prod[lru_pkg::PROD_W-1:lru_pkg::DIV_SHIFT];
    assign w_base = lru_pkg::ADDR_W'(w_quot) * lru_pkg::ADDR_W'(lru_pkg::WORDS_PER_PAGE);

    // Shared age unit: one subtract, one compare per scanned frame
    assign w_age = r_ref_idx - r_last_use[r_idx];

    // Victim choice in the update step
    assign w_evict    = !r_hit && !r_empty_found;
    assign w_upd_slot = (!r_hit && r_empty_found) ? r_empty_slot : r_slot;

    // Sequencer: next state and outputs
    always_comb begin
        n_state       = r_state;
        n_frames      = r_frames;
        n_valid       = r_valid;
        n_ref_idx     = r_ref_idx;
        n_fault       = r_fault;
        n_out_valid   = r_out_valid && i_out_stall;
        n_page        = r_page;
        n_offset      = r_offset;
        n_idx         = r_idx;
        n_limit_m1    = r_limit_m1;
        n_hit         = r_hit;
        n_slot        = r_slot;
        n_empty_found = r_empty_found;
        n_empty_slot  = r_empty_slot;
        n_best_age    = r_best_age;
        n_best_page   = r_best_page;
        n_out         = r_out;
        w_en          = 1'b0;
        w_slot        = w_upd_slot;
        w_fill        = 1'b0;

        if (i_cfg_valid) begin
            n_frames = i_cfg_data;
        end

        unique case (r_state)
            lru_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_page        = w_quot[PW-1:0];
                    n_offset      = lru_pkg::OFFSET_W'(i_in_item.word_address - w_base);
                    n_idx         = '0;
                    n_hit         = 1'b0;
                    n_slot        = '0;
                    n_empty_found = 1'b0;
                    n_empty_slot  = '0;
                    n_best_age    = '0;
                    n_best_page   = '0;
                    // clamp frame count to 1..MAX_FRAMES
                    if (r_frames == '0) begin
                        n_limit_m1 = '0;
                    end else if (r_frames > lru_pkg::CFG_W'(NF)) begin
                        n_limit_m1 = FW'(NF - 1);
                    end else begin
                        n_limit_m1 = FW'(r_frames - 1'b1);
                    end
                    if (i_in_item.start_run) begin
                        n_valid   = '0;
                        n_ref_idx = '0;
                        n_fault   = '0;
                    end
                    n_state = lru_pkg::ST_SCAN;
                end
            end
            lru_pkg::ST_SCAN: begin
                if (r_valid[r_idx] && (r_frame_page[r_idx] == r_page)) begin
                    n_hit   = 1'b1;
                    n_slot  = r_idx;
                    n_state = lru_pkg::ST_UPDATE;
                end else begin
                    // first empty frame wins a fill
                    if (!r_valid[r_idx] && !r_empty_found) begin
                        n_empty_found = 1'b1;
                        n_empty_slot  = r_idx;
                    end
                    // oldest stamp, lowest frame on a tie
                    if ((r_idx == '0) || (w_age > r_best_age)) begin
                        n_best_age  = w_age;
                        n_slot      = r_idx;
                        n_best_page = r_frame_page[r_idx];
                    end
                    if (r_idx == r_limit_m1) begin
                        n_state = lru_pkg::ST_UPDATE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            lru_pkg::ST_UPDATE: begin
                if (w_out_free) begin
                    w_en   = 1'b1;
                    w_fill = !r_hit;
                    if (!r_hit) begin
                        n_valid[w_upd_slot] = 1'b1;
                        n_fault = (r_fault != '1) ? r_fault + 1'b1 : r_fault;
                    end
                    n_ref_idx = r_ref_idx + 1'b1;
                    n_out.hit           = r_hit;
                    n_out.frame_slot    = w_upd_slot;
                    n_out.page_number   = r_page;
                    n_out.page_offset   = r_offset;
                    n_out.evicted_valid = w_evict;
                    n_out.evicted_page  = w_evict ? r_best_page : '0;
                    n_out.fault_total   = n_fault;
                    n_out_valid = 1'b1;
                    n_state     = lru_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lru_pkg::ST_IDLE;
            end
        endcase
    end

    // State register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lru_pkg::ST_IDLE;
            r_frames    <= lru_pkg::CFG_W'(lru_pkg::CFG_RESET);
            r_valid     <= '0;
            r_ref_idx   <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frames    <= n_frames;
            r_valid     <= n_valid;
            r_ref_idx   <= n_ref_idx;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_page        <= n_page;
        r_offset      <= n_offset;
        r_idx         <= n_idx;
        r_limit_m1    <= n_limit_m1;
        r_hit         <= n_hit;
        r_slot        <= n_slot;
        r_empty_found <= n_empty_found;
        r_empty_slot  <= n_empty_slot;
        r_best_age    <= n_best_age;
        r_best_page   <= n_best_page;
        r_out         <= n_out;
    end

    // Frame table write: page on a fault, recency stamp always
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last_use[w_slot] <= r_ref_idx;
            if (w_fill) begin
                r_frame_page[w_slot] <= r_page;
            end
        end
    end

endmodule

// ----- rtl/core/lru_checker.sv -----
module lru_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       o_in_stall,
    input  lru_pkg::t_in_item          i_in_item,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  lru_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_valid,
    input  logic                       o_cfg_ready,
    input  logic [lru_pkg::CFG_W-1:0]  i_cfg_data
);

    // A hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.hit) |->
            (!o_out_item.evicted_valid && (o_out_item.evicted_page == '0)))
        else $error("hit result carries an eviction");

    // An eviction only happens on a fault, which is counted
    a_evict_is_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.evicted_valid) |->
            (!o_out_item.hit && (o_out_item.fault_total != '0)))
        else $error("eviction without a counted fault");

    // The block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled while item in progress");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind lru_page_replacement_unit lru_checker u_lru_checker (.*);

// ----- bench/tb_top.sv -----
module tb_top;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SHOWN_MISMATCHES = 10;

    // Clock, reset and block ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    lru_pkg::t_in_item in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    lru_pkg::t_out_item out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [lru_pkg::CFG_W-1:0] cfg_data = '0;

    // Bench bookkeeping
    lru_pkg::t_in_item pend_refs[$];
    lru_pkg::t_out_item due_results[$];
    int mismatches = 0;
    int cycle_count = 0;
    bit steady = 1'b0;
    lru_pkg::t_out_item seen_res;
    lru_pkg::t_out_item want_res;

    // Predictor state: page table contents, recency stamps, counters, frame count
    logic [lru_pkg::PAGE_W-1:0] page_in_frame[lru_pkg::MAX_FRAMES];
    bit frame_full[lru_pkg::MAX_FRAMES];
    logic [lru_pkg::STAMP_W-1:0] frame_stamp[lru_pkg::MAX_FRAMES];
    logic [lru_pkg::STAMP_W-1:0] ref_seq = '0;
    logic [lru_pkg::COUNT_W-1:0] faults_so_far = '0;
    logic [lru_pkg::CFG_W-1:0] frames_cfg = lru_pkg::CFG_W'(lru_pkg::CFG_RESET);

    lru_page_replacement_unit dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_item(in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item(out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Frame count as the policy sees it: 0 acts as 1, large values clamp
    function automatic int frames_limit();
        if (frames_cfg == 0) return 1;
        if (frames_cfg > lru_pkg::MAX_FRAMES) return lru_pkg::MAX_FRAMES;
        return int'(frames_cfg);
    endfunction

    // LRU lookup / fill / evict for one reference, updating the page table
    function automatic lru_pkg::t_out_item replace_page(input lru_pkg::t_in_item ref_item);
        lru_pkg::t_out_item res;
        int lim;
        int slot;
        int pg;
        int off;
        int addr;
        bit found;
        logic [lru_pkg::STAMP_W-1:0] age;
        logic [lru_pkg::STAMP_W-1:0] oldest;
        res = '0;
        if (ref_item.start_run) begin
            for (int i = 0; i < lru_pkg::MAX_FRAMES; i++) begin
                page_in_frame[i] = '0;
                frame_full[i] = 1'b0;
                frame_stamp[i] = '0;
            end
            ref_seq = '0;
            faults_so_far = '0;
        end
        lim = frames_limit();
        addr = int'(ref_item.word_address);
        pg = (addr / lru_pkg::WORDS_PER_PAGE) % lru_pkg::NUM_PAGES;
        off = addr % lru_pkg::WORDS_PER_PAGE;
        found = 1'b0;
        slot = 0;
        for (int i = 0; i < lim; i++) begin
            if (!found && frame_full[i]
                && page_in_frame[i] == pg[lru_pkg::PAGE_W-1:0]) begin
                slot = i;
                found = 1'b1;
            end
        end
        if (found) begin
            res.hit = 1'b1;
        end else begin
            // lowest empty frame first
            for (int i = 0; i < lim; i++) begin
                if (!found && !frame_full[i]) begin
                    slot = i;
                    found = 1'b1;
                end
            end
            // otherwise the oldest stamp, lowest frame on a tie
            if (!found) begin
                oldest = '0;
                for (int i = 0; i < lim; i++) begin
                    age = ref_seq - frame_stamp[i];
                    if (i == 0 || age > oldest) begin
                        oldest = age;
                        slot = i;
                    end
                end
                res.evicted_valid = 1'b1;
                res.evicted_page = page_in_frame[slot];
            end
            page_in_frame[slot] = pg[lru_pkg::PAGE_W-1:0];
            frame_full[slot] = 1'b1;
            if (faults_so_far != '1) faults_so_far = faults_so_far + 1'b1;
        end
        frame_stamp[slot] = ref_seq;
        ref_seq = ref_seq + 1'b1;
        res.frame_slot = slot[lru_pkg::FRAME_W-1:0];
        res.page_number = pg[lru_pkg::PAGE_W-1:0];
        res.page_offset = off[lru_pkg::OFFSET_W-1:0];
        res.fault_total = faults_so_far;
        return res;
    endfunction

    task automatic add_ref(input int addr, input bit start);
        lru_pkg::t_in_item it;
        it.word_address = addr[lru_pkg::ADDR_W-1:0];
        it.start_run = start;
        pend_refs = {pend_refs, it};
    endtask

    // Random references: mostly a working set a bit larger than the frame
    // count, so hits, fills and evictions all show up; some full-range noise
    task automatic add_random(input int count);
        int span;
        int base;
        int pg;
        for (int n = 0; n < count; n++) begin
            if (n % 25 == 0) begin
                span = frames_limit() + 2;
                base = $urandom_range(lru_pkg::NUM_PAGES - span, 0);
            end
            pg = base + $urandom_range(span - 1, 0);
            if ($urandom_range(99) < 15)
                add_ref($urandom_range((1 << lru_pkg::ADDR_W) - 1, 0),
                        $urandom_range(99) < 2);
            else
                add_ref(pg * lru_pkg::WORDS_PER_PAGE
                        + $urandom_range(lru_pkg::WORDS_PER_PAGE - 1, 0),
                        $urandom_range(99) < 2);
        end
    endtask

    // Wait until every queued item went in and every result came back
    task automatic drain();
        while (pend_refs.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_frames(input logic [lru_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        frames_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    // Driver: presents queued items, holds an item while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) due_results = {due_results, replace_page(in_item)};
            if (pend_refs.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
                in_item <= pend_refs.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: takes results, compares with the oldest prediction
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                seen_res = out_item;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display("unexpected result: hit=%0d slot=%0d page=%0d",
                                 seen_res.hit, seen_res.frame_slot, seen_res.page_number);
                end else begin
                    want_res = due_results.pop_front();
                    if (seen_res.hit !== want_res.hit
                        || seen_res.frame_slot !== want_res.frame_slot
                        || seen_res.page_number !== want_res.page_number
                        || seen_res.page_offset !== want_res.page_offset
                        || seen_res.evicted_valid !== want_res.evicted_valid
                        || seen_res.evicted_page !== want_res.evicted_page
                        || seen_res.fault_total !== want_res.fault_total) begin
                        mismatches++;
                        if (mismatches <= SHOWN_MISMATCHES) begin
                            $display("mismatch: want hit=%0d slot=%0d page=%0d off=%0d ev=%0d/%0d faults=%0d",
                                     want_res.hit, want_res.frame_slot,
                                     want_res.page_number, want_res.page_offset,
                                     want_res.evicted_valid, want_res.evicted_page,
                                     want_res.fault_total);
                            $display("          got  hit=%0d slot=%0d page=%0d off=%0d ev=%0d/%0d faults=%0d",
                                     seen_res.hit, seen_res.frame_slot,
                                     seen_res.page_number, seen_res.page_offset,
                                     seen_res.evicted_valid, seen_res.evicted_page,
                                     seen_res.fault_total);
                        end
                    end
                end
            end
            out_stall <= !steady && ($urandom_range(99) < 32);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        for (int i = 0; i < lru_pkg::MAX_FRAMES; i++) begin
            page_in_frame[i] = '0;
            frame_full[i] = 1'b0;
            frame_stamp[i] = '0;
        end

        // Directed, four frames after reset: fills, hits, aliasing addresses,
        // a hit refreshing recency before an eviction, a restart
        add_ref(0, 1'b1);
        add_ref(9, 1'b0);
        add_ref(10, 1'b0);
        add_ref(319, 1'b0);
        add_ref(320, 1'b0);
        add_ref(511, 1'b0);
        add_ref(5, 1'b0);
        add_ref(25, 1'b0);
        add_ref(318, 1'b0);
        add_ref(100, 1'b0);
        add_ref(256, 1'b1);
        add_ref(0, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        drain();

        // Zero frames acts as one: every new page evicts
        write_frames(5'd0);
        add_ref(30, 1'b0);
        add_ref(45, 1'b0);
        add_ref(31, 1'b0);
        add_random(60);
        drain();

        // Above the maximum clamps to sixteen frames
        write_frames(5'd31);
        add_random(150);
        drain();

        // Shrink: upper frames keep their pages but are out of play
        write_frames(5'd3);
        add_random(120);
        drain();

        // Grow back to full size, no idling on either side
        write_frames(5'd16);
        steady = 1'b1;
        add_random(150);
        drain();
        steady = 1'b0;

        write_frames(5'd17);
        add_random(100);
        drain();

        write_frames(5'd1);
        add_random(80);
        drain();

        // Back-to-back run on two frames: three pages in turn fault every
        // time, then a few random pages over four
        write_frames(5'd2);
        steady = 1'b1;
        for (int j = 0; j < 30; j++)
            add_ref((j % 3) * lru_pkg::WORDS_PER_PAGE
                    + $urandom_range(lru_pkg::WORDS_PER_PAGE - 1, 0), j == 0);
        for (int j = 0; j < 20; j++)
            add_ref($urandom_range(3, 0) * lru_pkg::WORDS_PER_PAGE
                    + $urandom_range(lru_pkg::WORDS_PER_PAGE - 1, 0), 1'b0);
        drain();
        steady = 1'b0;

        // Random frame counts
        repeat (4) begin
            write_frames(lru_pkg::CFG_W'($urandom_range((1 << lru_pkg::CFG_W) - 1, 0)));
            add_random(80);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
